// File: design/rgb2ypbpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YPbPr package
// Widths, beat types and BT.601 weights shared by the conversion pipeline.
// ----------------------------------------------------------------------------
package rgb2ypbpr_pkg;

  // Sample and result formats.
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned QUO_W       = FRAC_BITS + 1;

  // The weights are integers scaled by one million.
  localparam int unsigned        SCALE_W   = 20;
  localparam logic [SCALE_W-1:0] COEF_SCALE = 20'd1000000;
  localparam int unsigned        WGT_W     = SCALE_W + 1;

  // Product of a sample and a weight, and the sum of three of them.
  localparam int unsigned PROD_W = SAMPLE_BITS + 1 + WGT_W;
  localparam int unsigned SUM_W  = PROD_W;
  // Magnitude of a sum: at most one million times the denominator.
  localparam int unsigned MAG_W  = SAMPLE_BITS + SCALE_W;
  // Scaled denominator (one million times D) and the divisor (twice that).
  localparam int unsigned DEN_W  = SAMPLE_BITS + SCALE_W;
  localparam int unsigned DIV_W  = DEN_W + 1;
  // Partial remainder: must hold the divisor shifted up by the quotient width.
  localparam int unsigned REM_W  = DIV_W + QUO_W;

  // One color channel inside the divider.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } lane_t;

  // One pixel inside the divider: Y, Pb and Pr lanes plus the frame flag.
  typedef struct packed {
    lane_t [2:0] lane;
    logic        eoi;
  } div_beat_t;

  // BT.601 weight for output row (Y, Pb, Pr) and input column (R, G, B).
  function automatic logic signed [WGT_W-1:0] coef(input logic [1:0] row,
                                                    input logic [1:0] col);
    logic signed [WGT_W-1:0] w;
    unique case ({row, col})
      4'b00_00: w = 21'sd299000;
      4'b00_01: w = 21'sd587000;
      4'b00_10: w = 21'sd114000;
      4'b01_00: w = -21'sd168736;
      4'b01_01: w = -21'sd331264;
      4'b01_10: w = 21'sd500000;
      4'b10_00: w = 21'sd500000;
      4'b10_01: w = -21'sd418688;
      4'b10_10: w = -21'sd81312;
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: design/rgb2ypbpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YPbPr front end
// Four register stages: clamp, weight products, row sums, and the rounded
// dividend that feeds the quotient pipeline.
// ----------------------------------------------------------------------------
module rgb2ypbpr_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] denom_i,
  input  logic [rgb2ypbpr_pkg::DEN_W-1:0]       den_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] red_i,
  input  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] green_i,
  input  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] blue_i,
  input  logic                                  eoi_i,
  output logic                                  dn_valid_o,
  input  logic                                  dn_ready_i,
  output rgb2ypbpr_pkg::div_beat_t              dn_data_o
);

  // Stage valids and per-stage advance enables.
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic en_a, en_b, en_c, en_d;

  // Stage payloads.
  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] a_comp_q [3];
  logic                                  a_eoi_q;
  logic signed [rgb2ypbpr_pkg::PROD_W-1:0] b_prod_q [3][3];
  logic                                  b_eoi_q;
  logic signed [rgb2ypbpr_pkg::SUM_W-1:0] c_sum_q [3];
  logic                                  c_eoi_q;
  rgb2ypbpr_pkg::div_beat_t              d_data_q;
  rgb2ypbpr_pkg::div_beat_t              d_data_d;
  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] in_comp [3];

  // A stage moves when it is empty or the next one moves.
  assign en_d       = !d_v_q || dn_ready_i;
  assign en_c       = !c_v_q || en_d;
  assign en_b       = !b_v_q || en_c;
  assign en_a       = !a_v_q || en_b;
  assign in_ready_o = en_a;
  assign dn_valid_o = d_v_q;
  assign dn_data_o  = d_data_q;

  // Clamp each sample to the denominator.
  assign in_comp[0] = (red_i   > denom_i) ? denom_i : red_i;
  assign in_comp[1] = (green_i > denom_i) ? denom_i : green_i;
  assign in_comp[2] = (blue_i  > denom_i) ? denom_i : blue_i;

  // Sign, magnitude and rounding offset for the dividend of each row.
  always_comb begin
    logic signed [rgb2ypbpr_pkg::SUM_W-1:0] abs_v;
    logic [rgb2ypbpr_pkg::MAG_W-1:0]        mag;
    d_data_d     = '0;
    d_data_d.eoi = c_eoi_q;
    for (int r = 0; r < 3; r++) begin
      abs_v = c_sum_q[r][rgb2ypbpr_pkg::SUM_W-1] ? -c_sum_q[r] : c_sum_q[r];
      mag   = abs_v[rgb2ypbpr_pkg::MAG_W-1:0];
      d_data_d.lane[r].neg = c_sum_q[r][rgb2ypbpr_pkg::SUM_W-1];
      d_data_d.lane[r].quo = '0;
      d_data_d.lane[r].rem =
        (rgb2ypbpr_pkg::REM_W'(mag) << (rgb2ypbpr_pkg::FRAC_BITS + 1)) +
        rgb2ypbpr_pkg::REM_W'(den_i);
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= in_valid_i;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
      if (en_d) d_v_q <= c_v_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      for (int k = 0; k < 3; k++) a_comp_q[k] <= in_comp[k];
      a_eoi_q <= eoi_i;
    end
    if (en_b && a_v_q) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          b_prod_q[r][k] <= $signed({1'b0, a_comp_q[k]}) *
                            rgb2ypbpr_pkg::coef(2'(r), 2'(k));
        end
      end
      b_eoi_q <= a_eoi_q;
    end
    if (en_c && b_v_q) begin
      for (int r = 0; r < 3; r++) begin
        c_sum_q[r] <= b_prod_q[r][0] + b_prod_q[r][1] + b_prod_q[r][2];
      end
      c_eoi_q <= b_eoi_q;
    end
    if (en_d && c_v_q) begin
      d_data_q <= d_data_d;
    end
  end

endmodule

// File: design/rgb2ypbpr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YPbPr divider stage
// One restoring division step for all three channels: one quotient bit per
// channel, then the partial remainder shifts left by one.
// ----------------------------------------------------------------------------
module rgb2ypbpr_div_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rgb2ypbpr_pkg::DIV_W-1:0] divisor_i,
  input  logic                            up_valid_i,
  output logic                            up_ready_o,
  input  rgb2ypbpr_pkg::div_beat_t        up_data_i,
  output logic                            dn_valid_o,
  input  logic                            dn_ready_i,
  output rgb2ypbpr_pkg::div_beat_t        dn_data_o
);

  logic                     v_q;
  logic                     en;
  rgb2ypbpr_pkg::div_beat_t data_q;
  rgb2ypbpr_pkg::div_beat_t data_d;
  logic [rgb2ypbpr_pkg::REM_W-1:0] div_top;

  assign en         = !v_q || dn_ready_i;
  assign up_ready_o = en;
  assign dn_valid_o = v_q;
  assign dn_data_o  = data_q;

  // Divisor aligned with the top quotient bit.
  assign div_top = rgb2ypbpr_pkg::REM_W'(divisor_i) << (rgb2ypbpr_pkg::QUO_W - 1);

  // Trial subtract, keep the difference when it does not borrow.
  always_comb begin
    logic [rgb2ypbpr_pkg::REM_W:0]   trial;
    logic [rgb2ypbpr_pkg::REM_W-1:0] kept;
    logic                            ge;
    data_d     = up_data_i;
    for (int r = 0; r < 3; r++) begin
      trial = {1'b0, up_data_i.lane[r].rem} - {1'b0, div_top};
      ge    = !trial[rgb2ypbpr_pkg::REM_W];
      kept  = ge ? trial[rgb2ypbpr_pkg::REM_W-1:0] : up_data_i.lane[r].rem;
      data_d.lane[r].rem = {kept[rgb2ypbpr_pkg::REM_W-2:0], 1'b0};
      data_d.lane[r].quo = {up_data_i.lane[r].quo[rgb2ypbpr_pkg::QUO_W-2:0], ge};
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= up_valid_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (en && up_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/rgb_to_ypbpr_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YPbPr normalize
// Clamps each RGB sample to the configured maximum, applies the BT.601
// weights and divides by the maximum, giving Y, Pb and Pr in Q1.15 with
// round to nearest, ties away from zero.
//
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_ready    red, green, blue, end of image
// out      output     out_valid/out_ready  luma, blue_diff, red_diff, end of image
// cfg      input      cfg_wr_en            max_value (16 bit, reset 255)
//
// One pixel per clock is accepted and delivered at full rate while out_ready stays high.
// Pixels pass through four front-end stages, sixteen division stages
// (one quotient bit per stage, set by the 16-bit result width) and the
// output register. Reset clears all valid bits and sets max_value to 255.
// A stalled output holds; each stage advances whenever the next one has
// room, so empty stages keep filling while the output waits.
// ----------------------------------------------------------------------------
module rgb_to_ypbpr_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic        end_of_image_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] luma_o,
  output logic signed [15:0] blue_diff_o,
  output logic signed [15:0] red_diff_o,
  output logic        end_of_image_out_o
);

  localparam int unsigned QUO_W = rgb2ypbpr_pkg::QUO_W;

  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] max_value_q;
  logic [rgb2ypbpr_pkg::SAMPLE_BITS-1:0] d_eff;
  logic [rgb2ypbpr_pkg::DEN_W-1:0]       den_q;
  logic [rgb2ypbpr_pkg::DEN_W-1:0]       den_d;
  logic [rgb2ypbpr_pkg::DIV_W-1:0]       divisor;

  logic                     div_valid [QUO_W+1];
  logic                     div_ready [QUO_W+1];
  rgb2ypbpr_pkg::div_beat_t div_data  [QUO_W+1];

  logic        out_valid_q;
  logic        out_en;
  logic [15:0] luma_q, luma_d;
  logic [15:0] pb_q, pb_d, pr_q, pr_d;
  logic        eoi_q;

  // Configuration register and the scaled denominator derived from it.
  assign d_eff   = (max_value_q == '0) ? rgb2ypbpr_pkg::SAMPLE_BITS'(1) : max_value_q;
  assign den_d   = rgb2ypbpr_pkg::DEN_W'(d_eff) *
                   rgb2ypbpr_pkg::DEN_W'(rgb2ypbpr_pkg::COEF_SCALE);
  assign divisor = {den_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= 16'd255;
      den_q       <= rgb2ypbpr_pkg::DEN_W'(255) *
                     rgb2ypbpr_pkg::DEN_W'(rgb2ypbpr_pkg::COEF_SCALE);
    end else begin
      if (cfg_wr_en_i) max_value_q <= cfg_wr_data_i;
      den_q <= den_d;
    end
  end

  // Clamp, weight, sum and form the rounded dividend.
  rgb2ypbpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .denom_i    (d_eff),
    .den_i      (den_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_i      (red_in_i),
    .green_i    (green_in_i),
    .blue_i     (blue_in_i),
    .eoi_i      (end_of_image_in_i),
    .dn_valid_o (div_valid[0]),
    .dn_ready_i (div_ready[0]),
    .dn_data_o  (div_data[0])
  );

  // Quotient pipeline, most significant bit first.
  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    rgb2ypbpr_div_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .divisor_i  (divisor),
      .up_valid_i (div_valid[s]),
      .up_ready_o (div_ready[s]),
      .up_data_i  (div_data[s]),
      .dn_valid_o (div_valid[s+1]),
      .dn_ready_i (div_ready[s+1]),
      .dn_data_o  (div_data[s+1])
    );
  end

  // Apply the signs; luma cannot be negative, the check mirrors the clamp at zero.
  assign luma_d = div_data[QUO_W].lane[0].neg ? '0 : div_data[QUO_W].lane[0].quo;
  assign pb_d   = div_data[QUO_W].lane[1].neg ? (16'd0 - div_data[QUO_W].lane[1].quo)
                                              : div_data[QUO_W].lane[1].quo;
  assign pr_d   = div_data[QUO_W].lane[2].neg ? (16'd0 - div_data[QUO_W].lane[2].quo)
                                              : div_data[QUO_W].lane[2].quo;

  // Output register.
  assign out_en           = !out_valid_q || out_ready_i;
  assign div_ready[QUO_W] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= div_valid[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && div_valid[QUO_W]) begin
      luma_q <= luma_d;
      pb_q   <= pb_d;
      pr_q   <= pr_d;
      eoi_q  <= div_data[QUO_W].eoi;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign luma_o             = luma_q;
  assign blue_diff_o        = pb_q;
  assign red_diff_o         = pr_q;
  assign end_of_image_out_o = eoi_q;

`ifndef SYNTHESIS
  // With no beat waiting at the output every stage can advance.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // The registered scaled denominator matches max_value after any cycle without a write.
  a_den_tracks_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr_en_i |=> den_q == den_d)
    else $error("scaled denominator out of step with max_value");
`endif

endmodule

// File: sim/rgb_to_ypbpr_normalize_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YPbPr normalize testbench
// Streams RGB pixels through the converter under several image maximum
// settings and checks every Y, Pb, Pr and end-of-image result beat against
// an in-bench BT.601 predictor, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module rgb_to_ypbpr_normalize_tb;

  localparam int unsigned LATENCY       = 21;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_PIXELS = 1300;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 40;

  // One converted pixel as it leaves the block.
  typedef struct packed {
    logic [15:0] luma;
    logic [15:0] pb;
    logic [15:0] pr;
    logic        eoi;
  } ypbpr_t;

  // Predicts each converted pixel and matches it against the output beats.
  class ypbpr_scoreboard;
    ypbpr_t      expected_q[$];
    logic [15:0] max_value;
    int unsigned errors;
    int unsigned pixels_in;
    int unsigned results_out;
    int unsigned clamped;
    int unsigned eoi_marks;

    function new();
      max_value = 16'd255;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("mismatch at result %0d: %s", results_out, msg);
      end
    endfunction

    // Rounds sum * 2^FRAC_BITS / (1e6 * d) to nearest, ties away from zero.
    function longint scale_to_fixed(longint sum, longint d);
      longint mag;
      longint den;
      longint q;
      mag = (sum < 0) ? -sum : sum;
      den = 64'sd1000000 * d;
      q   = ((mag <<< (rgb2ypbpr_pkg::FRAC_BITS + 1)) + den) / (2 * den);
      return (sum < 0) ? -q : q;
    endfunction

    function logic [15:0] sat_signed(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function ypbpr_t convert(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic eoi);
      longint d;
      longint cr;
      longint cg;
      longint cb;
      longint y;
      ypbpr_t res;
      d  = (max_value == 16'd0) ? 1 : max_value;
      cr = (r > d) ? d : r;
      cg = (g > d) ? d : g;
      cb = (b > d) ? d : b;
      if (r > d) clamped++;
      if (g > d) clamped++;
      if (b > d) clamped++;
      y = scale_to_fixed(299000 * cr + 587000 * cg + 114000 * cb, d);
      res.luma = (y < 0) ? 16'd0 : (y > 65535) ? 16'hFFFF : y[15:0];
      res.pb   = sat_signed(scale_to_fixed(-168736 * cr - 331264 * cg + 500000 * cb, d));
      res.pr   = sat_signed(scale_to_fixed(500000 * cr - 418688 * cg - 81312 * cb, d));
      res.eoi  = eoi;
      return res;
    endfunction

    function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic eoi);
      expected_q.push_back(convert(r, g, b, eoi));
      pixels_in++;
      if (eoi) eoi_marks++;
    endfunction

    function void check_result(logic [15:0] luma, logic [15:0] pb, logic [15:0] pr,
                               logic eoi);
      ypbpr_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat luma=%0d pb=%0d pr=%0d eoi=%0b",
                         luma, $signed(pb), $signed(pr), eoi));
        results_out++;
        return;
      end
      exp = expected_q.pop_front();
      if (luma !== exp.luma)
        report($sformatf("luma got %0d expected %0d", luma, exp.luma));
      if (pb !== exp.pb)
        report($sformatf("blue_diff got %0d expected %0d", $signed(pb), $signed(exp.pb)));
      if (pr !== exp.pr)
        report($sformatf("red_diff got %0d expected %0d", $signed(pr), $signed(exp.pr)));
      if (eoi !== exp.eoi)
        report($sformatf("end_of_image got %0b expected %0b", eoi, exp.eoi));
      results_out++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [15:0] cfg_wr_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] red_in_i;
  logic [15:0] green_in_i;
  logic [15:0] blue_in_i;
  logic        end_of_image_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] luma_o;
  logic signed [15:0] blue_diff_o;
  logic signed [15:0] red_diff_o;
  logic        end_of_image_out_o;

  ypbpr_scoreboard sb;
  int unsigned     cycle_count;
  int unsigned     long_hold_cycles;
  bit              no_idle;

  rgb_to_ypbpr_normalize u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .red_in_i           (red_in_i),
    .green_in_i         (green_in_i),
    .blue_in_i          (blue_in_i),
    .end_of_image_in_i  (end_of_image_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .luma_o             (luma_o),
    .blue_diff_o        (blue_diff_o),
    .red_diff_o         (red_diff_o),
    .end_of_image_out_o (end_of_image_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Every accepted output beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(luma_o, blue_diff_o, red_diff_o, end_of_image_out_o);
    end
  end

  // Mostly short gaps, now and then a long one; none while no_idle is set.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples are biased toward zero, the denominator and values above it.
  function automatic logic [15:0] pick_sample(input logic [15:0] maxv);
    int unsigned d;
    int unsigned sel;
    d   = (maxv == 16'd0) ? 1 : maxv;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 16'd0;
    if (sel < 18) return d[15:0];
    if (sel < 28) return (d < 65535) ? 16'($urandom_range(d + 1, 65535)) : 16'hFFFF;
    if (sel < 40) return 16'($urandom());
    return 16'($urandom_range(0, d));
  endfunction

  // Output side: random ready with an occasional long hold-off.
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk_i);
        long_hold_cycles = 0;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Offer one pixel and hold it until the block takes the beat.
  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic eoi);
    int unsigned gap;
    in_valid_i        <= 1'b1;
    red_in_i          <= r;
    green_in_i        <= g;
    blue_in_i         <= b;
    end_of_image_in_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(r, g, b, eoi);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted pixel has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // The register is only written with the pipeline empty.
  task automatic write_max(input logic [15:0] value);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.max_value  = value;
  endtask

  initial begin
    logic [15:0] plan [PHASES];
    int unsigned per_phase;
    sb = new();
    rst_ni            <= 1'b0;
    cfg_wr_en_i       <= 1'b0;
    cfg_wr_data_i     <= 16'd0;
    in_valid_i        <= 1'b0;
    red_in_i          <= 16'd0;
    green_in_i        <= 16'd0;
    blue_in_i         <= 16'd0;
    end_of_image_in_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels under the reset maximum of 255.
    send_pixel(16'd0, 16'd0, 16'd0, 1'b0);
    send_pixel(16'd255, 16'd255, 16'd255, 1'b0);
    send_pixel(16'd255, 16'd0, 16'd0, 1'b0);
    send_pixel(16'd0, 16'd255, 16'd0, 1'b0);
    send_pixel(16'd0, 16'd0, 16'd255, 1'b0);
    send_pixel(16'd0, 16'd255, 16'd255, 1'b0);
    send_pixel(16'd255, 16'd0, 16'd255, 1'b0);
    send_pixel(16'd255, 16'd255, 16'd0, 1'b1);
    send_pixel(16'd128, 16'd128, 16'd128, 1'b0);
    send_pixel(16'd1, 16'd0, 16'd0, 1'b0);
    send_pixel(16'd0, 16'd0, 16'd1, 1'b0);
    send_pixel(16'd256, 16'd0, 16'd0, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hAAAA, 16'h5555, 16'h00FF, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 16'hFF00, 1'b1);
    send_pixel(16'd255, 16'd0, 16'hFFFF, 1'b0);

    // Denominator plan: smallest, zero, full scale, then assorted values.
    plan = '{16'd1, 16'd0, 16'd65535, 16'd1023, 16'd3,
             16'($urandom_range(2, 65534)), 16'($urandom_range(2, 1000)), 16'd255};
    per_phase = RANDOM_PIXELS / PHASES;

    for (int p = 0; p < PHASES; p++) begin
      write_max(plan[p]);
      // Full-rate phase: the receiver holds off while the sender keeps going,
      // so the pipeline fills and backs up onto the input.
      if (plan[p] == 16'd65535) begin
        no_idle = 1'b1;
        long_hold_cycles = HOLD_CYCLES;
        send_pixel(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 1'b1);
      end
      for (int i = 0; i < per_phase; i++) begin
        send_pixel(pick_sample(sb.max_value), pick_sample(sb.max_value),
                   pick_sample(sb.max_value), $urandom_range(0, 15) == 0);
      end
      no_idle = 1'b0;
    end

    drain();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Converted %0d pixels (%0d results) over %0d written maximum settings,",
             sb.pixels_in, sb.results_out, PHASES);
    $display("with %0d clamped samples and %0d end-of-image markers; %0d mismatches.",
             sb.clamped, sb.eoi_marks, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
